[src/acv_pkg.sv]
// Package for the ANSI text console: shared constants, command codes and control structs.
`timescale 1ns / 1ps
`default_nettype none
package acv_pkg;

   localparam int COLUMNS_DEF = 32;
   localparam int ROWS_DEF    = 24;
   localparam int ESC_LEN_DEF = 16;

   localparam logic [2:0] CMD_NONE      = 3'd0;
   localparam logic [2:0] CMD_WRITE     = 3'd1;
   localparam logic [2:0] CMD_SCROLL    = 3'd2;
   localparam logic [2:0] CMD_CLR_ROW   = 3'd3;
   localparam logic [2:0] CMD_CLR_SCRN  = 3'd4;

   localparam logic [7:0] CH_NUL   = 8'h00;
   localparam logic [7:0] CH_BS    = 8'h08;
   localparam logic [7:0] CH_TAB   = 8'h09;
   localparam logic [7:0] CH_LF    = 8'h0a;
   localparam logic [7:0] CH_FF    = 8'h0c;
   localparam logic [7:0] CH_ESC   = 8'h1b;
   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_ZERO  = 8'h30;
   localparam logic [7:0] CH_NINE  = 8'h39;
   localparam logic [7:0] CH_SEMI  = 8'h3b;
   localparam logic [7:0] CH_UP    = 8'h41;
   localparam logic [7:0] CH_DOWN  = 8'h42;
   localparam logic [7:0] CH_RIGHT = 8'h43;
   localparam logic [7:0] CH_LEFT  = 8'h44;
   localparam logic [7:0] CH_POS   = 8'h48;
   localparam logic [7:0] CH_CLRS  = 8'h4a;
   localparam logic [7:0] CH_CLRL  = 8'h4b;
   localparam logic [7:0] CH_LBRK  = 8'h5b;
   localparam logic [7:0] CH_POSF  = 8'h66;
   localparam logic [7:0] CH_COLOR = 8'h6d;
   localparam logic [7:0] CH_SAVE  = 8'h73;
   localparam logic [7:0] CH_REST  = 8'h75;

   localparam logic [9:0] COLOR_BASE = 10'd30;
   localparam logic [7:0] NUM_MAX    = 8'hff;

   typedef struct packed {
      logic wr;
      logic scroll;
   } put_flags_type;

   typedef struct packed {
      logic       done;
      logic [2:0] cmd;
   } seq_ctl_type;

endpackage
`default_nettype wire

[src/ansi_text_console.sv]
// ANSI text console: byte stream in, tile screen display commands out.
//
// req_valid/req_ready/req_char_in carry one character word per handshake.
// rsp_* carries display commands; every command of one input word carries
// the cursor position after that whole input, and rsp_last_result marks the
// final command of the input. An input that changes nothing gives one
// command with code none.
// Flow: a plain byte is accepted, the character unit finds its final cursor,
// then its command is sent, a write and then a scroll where both occur. An
// ESC not followed by '[' is replayed ahead of the byte. An escape sequence
// byte is applied by the sequence unit. An overflowed sequence is replayed
// through the shared character unit twice: once to find the cursor, then
// once more to send the commands of each replayed byte, a scroll that
// follows a write taking a command of its own.
// req_ready is high only while the sequencer is idle; it does not wait for
// the last command to be taken, which sits in the output register.
// When the receiver stalls the output register holds and the sequencer
// waits. Synchronous reset homes the cursor, clears palette and escape state.
`timescale 1ns / 1ps
`default_nettype none
module ansi_text_console #(
   parameter int COLUMNS = acv_pkg::COLUMNS_DEF,
   parameter int ROWS    = acv_pkg::ROWS_DEF,
   parameter int ESC_LEN = acv_pkg::ESC_LEN_DEF
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       req_valid,
   output logic                            req_ready,
   input  wire logic [7:0]                 req_char_in,
   output logic                            rsp_valid,
   input  wire logic                       rsp_ready,
   output logic [2:0]                      rsp_command,
   output logic [$clog2(COLUMNS)-1:0]      rsp_target_col,
   output logic [$clog2(ROWS)-1:0]         rsp_target_row,
   output logic [15:0]                     rsp_cell_value,
   output logic [$clog2(COLUMNS)-1:0]      rsp_cursor_col,
   output logic [$clog2(ROWS)-1:0]         rsp_cursor_row,
   output logic                            rsp_last_result
);
   localparam int CW   = $clog2(COLUMNS);
   localparam int RW   = $clog2(ROWS);
   localparam int BW   = $clog2(ESC_LEN);
   localparam int NW   = $clog2(ESC_LEN + 1);
   localparam int TW   = $clog2(2 * ESC_LEN + 3);

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_SIM  = 3'd1;
   localparam logic [2:0] ST_EMIT = 3'd2;
   localparam logic [2:0] ST_NONE = 3'd3;
   localparam logic [2:0] ST_SEQ  = 3'd4;

   logic [2:0]    state_ff, state_in;
   logic [7:0]    char_ff, char_in;
   logic [CW-1:0] cur_col_ff, cur_col_in, saved_col_ff, saved_col_in, wk_col_ff, wk_col_in;
   logic [RW-1:0] cur_row_ff, cur_row_in, saved_row_ff, saved_row_in, wk_row_ff, wk_row_in;
   logic [3:0]    palette_ff, palette_in;
   logic          esc_active_ff, esc_active_in;
   logic [NW-1:0] esc_count_ff, esc_count_in;
   logic [7:0]    first_ff, first_in, second_ff, second_in;
   logic [1:0]    num_idx_ff, num_idx_in;
   logic [NW-1:0] idx_ff, idx_in, rep_len_ff, rep_len_in;
   logic          rep_esc_ff, rep_esc_in;
   logic [TW-1:0] total_ff, total_in, sent_ff, sent_in;
   logic          sub_ff, sub_in;
   logic [7:0]    esc_buf_ff [ESC_LEN];
   logic          buf_wr;

   logic          rsp_valid_ff, rsp_valid_in;
   logic [2:0]    cmd_ff, cmd_in;
   logic [CW-1:0] tcol_ff, tcol_in, ccol_ff, ccol_in;
   logic [RW-1:0] trow_ff, trow_in, crow_ff, crow_in;
   logic [15:0]   value_ff, value_in;
   logic          last_ff, last_in;

   logic          slot_free;
   logic          accept;
   logic          final_step;
   logic [7:0]    step_byte;
   logic [CW-1:0] put_col, put_new_col, put_wr_col;
   logic [RW-1:0] put_row, put_new_row, put_wr_row;
   logic [15:0]   put_value;
   acv_pkg::put_flags_type put_flags;

   logic [CW-1:0] seq_col, seq_saved_col;
   logic [RW-1:0] seq_row, seq_saved_row;
   logic [3:0]    seq_palette;
   logic [7:0]    seq_first, seq_second;
   logic [1:0]    seq_num_idx;
   acv_pkg::seq_ctl_type seq_ctl;

   assign req_ready       = (state_ff == ST_IDLE);
   assign accept          = req_valid && req_ready;
   assign slot_free       = !rsp_valid_ff || rsp_ready;
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_command     = cmd_ff;
   assign rsp_target_col  = tcol_ff;
   assign rsp_target_row  = trow_ff;
   assign rsp_cell_value  = value_ff;
   assign rsp_cursor_col  = ccol_ff;
   assign rsp_cursor_row  = crow_ff;
   assign rsp_last_result = last_ff;

   assign final_step = (idx_ff == rep_len_ff);

   always_comb begin
      if (final_step) step_byte = (char_ff == acv_pkg::CH_ESC) ? acv_pkg::CH_NUL : char_ff;
      else if (rep_esc_ff) step_byte = acv_pkg::CH_ESC;
      else step_byte = esc_buf_ff[idx_ff[BW-1:0]];
   end

   assign put_col = (state_ff == ST_SIM) ? cur_col_ff : wk_col_ff;
   assign put_row = (state_ff == ST_SIM) ? cur_row_ff : wk_row_ff;

   acv_put #(.COLUMNS(COLUMNS), .ROWS(ROWS)) u_put (
      .col       (put_col),
      .row       (put_row),
      .palette   (palette_ff),
      .char_code (step_byte),
      .new_col   (put_new_col),
      .new_row   (put_new_row),
      .wr_col    (put_wr_col),
      .wr_row    (put_wr_row),
      .wr_value  (put_value),
      .flags     (put_flags)
   );

   acv_seq #(.COLUMNS(COLUMNS), .ROWS(ROWS)) u_seq (
      .char_code     (char_ff),
      .first_byte    (esc_count_ff == '0),
      .col           (cur_col_ff),
      .row           (cur_row_ff),
      .saved_col     (saved_col_ff),
      .saved_row     (saved_row_ff),
      .palette       (palette_ff),
      .first_num     (first_ff),
      .second_num    (second_ff),
      .num_idx       (num_idx_ff),
      .new_col       (seq_col),
      .new_row       (seq_row),
      .new_saved_col (seq_saved_col),
      .new_saved_row (seq_saved_row),
      .new_palette   (seq_palette),
      .new_first     (seq_first),
      .new_second    (seq_second),
      .new_num_idx   (seq_num_idx),
      .ctl           (seq_ctl)
   );

   always_comb begin
      logic [TW-1:0] total_next;
      logic          advance;
      logic          load;
      total_next    = total_ff + TW'(put_flags.wr) + TW'(put_flags.scroll);
      advance       = 1'b0;
      load          = 1'b0;
      state_in      = state_ff;
      char_in       = char_ff;
      cur_col_in    = cur_col_ff;
      cur_row_in    = cur_row_ff;
      saved_col_in  = saved_col_ff;
      saved_row_in  = saved_row_ff;
      wk_col_in     = wk_col_ff;
      wk_row_in     = wk_row_ff;
      palette_in    = palette_ff;
      esc_active_in = esc_active_ff;
      esc_count_in  = esc_count_ff;
      first_in      = first_ff;
      second_in     = second_ff;
      num_idx_in    = num_idx_ff;
      idx_in        = idx_ff;
      rep_len_in    = rep_len_ff;
      rep_esc_in    = rep_esc_ff;
      total_in      = total_ff;
      sent_in       = sent_ff;
      sub_in        = sub_ff;
      buf_wr        = 1'b0;
      cmd_in        = cmd_ff;
      tcol_in       = tcol_ff;
      trow_in       = trow_ff;
      value_in      = value_ff;
      ccol_in       = cur_col_ff;
      crow_in       = cur_row_ff;
      last_in       = last_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               char_in    = req_char_in;
               wk_col_in  = cur_col_ff;
               wk_row_in  = cur_row_ff;
               idx_in     = '0;
               total_in   = '0;
               sent_in    = '0;
               sub_in     = 1'b0;
               rep_len_in = '0;
               rep_esc_in = 1'b0;
               state_in   = ST_SIM;
               if (esc_active_ff && esc_count_ff == '0 && req_char_in != acv_pkg::CH_LBRK) begin
                  rep_len_in = NW'(1);
                  rep_esc_in = 1'b1;
               end else if (esc_active_ff && esc_count_ff >= NW'(ESC_LEN)) begin
                  rep_len_in = NW'(ESC_LEN);
               end else if (esc_active_ff) begin
                  state_in = ST_SEQ;
               end
               if (state_in == ST_SIM) begin
                  esc_active_in = (req_char_in == acv_pkg::CH_ESC);
                  if (req_char_in == acv_pkg::CH_ESC) begin
                     esc_count_in = '0;
                     first_in     = '0;
                     second_in    = '0;
                     num_idx_in   = '0;
                  end
               end
            end
         end
         ST_SIM: begin
            cur_col_in = put_new_col;
            cur_row_in = put_new_row;
            total_in   = total_next;
            if (final_step) begin
               idx_in   = '0;
               state_in = (total_next == '0) ? ST_NONE : ST_EMIT;
            end else begin
               idx_in = idx_ff + NW'(1);
            end
         end
         ST_EMIT: begin
            if (slot_free) begin
               if (sub_ff) begin
                  load    = 1'b1;
                  cmd_in  = acv_pkg::CMD_SCROLL;
                  sub_in  = 1'b0;
                  advance = 1'b1;
               end else if (put_flags.wr) begin
                  load   = 1'b1;
                  cmd_in = acv_pkg::CMD_WRITE;
                  if (put_flags.scroll) sub_in = 1'b1;
                  else advance = 1'b1;
               end else begin
                  load    = put_flags.scroll;
                  cmd_in  = acv_pkg::CMD_SCROLL;
                  advance = 1'b1;
               end
               if (load) begin
                  sent_in = sent_ff + TW'(1);
                  last_in = (sent_ff + TW'(1) == total_ff);
                  if (cmd_in == acv_pkg::CMD_WRITE) begin
                     tcol_in  = put_wr_col;
                     trow_in  = put_wr_row;
                     value_in = put_value;
                  end else begin
                     tcol_in  = '0;
                     trow_in  = '0;
                     value_in = '0;
                  end
               end else begin
                  cmd_in = cmd_ff;
               end
               if (advance) begin
                  wk_col_in = put_new_col;
                  wk_row_in = put_new_row;
                  if (final_step) state_in = ST_IDLE;
                  else idx_in = idx_ff + NW'(1);
               end
            end
         end
         ST_NONE: begin
            if (slot_free) begin
               load     = 1'b1;
               cmd_in   = acv_pkg::CMD_NONE;
               tcol_in  = '0;
               trow_in  = '0;
               value_in = '0;
               last_in  = 1'b1;
               state_in = ST_IDLE;
            end
         end
         ST_SEQ: begin
            if (slot_free) begin
               load          = 1'b1;
               buf_wr        = 1'b1;
               esc_count_in  = esc_count_ff + NW'(1);
               if (seq_ctl.done) esc_active_in = 1'b0;
               cur_col_in    = seq_col;
               cur_row_in    = seq_row;
               saved_col_in  = seq_saved_col;
               saved_row_in  = seq_saved_row;
               palette_in    = seq_palette;
               first_in      = seq_first;
               second_in     = seq_second;
               num_idx_in    = seq_num_idx;
               cmd_in        = seq_ctl.cmd;
               tcol_in       = '0;
               trow_in       = (seq_ctl.cmd == acv_pkg::CMD_CLR_ROW) ? cur_row_ff : '0;
               value_in      = '0;
               ccol_in       = seq_col;
               crow_in       = seq_row;
               last_in       = 1'b1;
               state_in      = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
      if (load) rsp_valid_in = 1'b1;
      else if (rsp_ready) rsp_valid_in = 1'b0;
      else rsp_valid_in = rsp_valid_ff;
      if (!load) begin
         ccol_in = ccol_ff;
         crow_in = crow_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         cur_col_ff    <= '0;
         cur_row_ff    <= '0;
         saved_col_ff  <= '0;
         saved_row_ff  <= '0;
         palette_ff    <= '0;
         esc_active_ff <= 1'b0;
         esc_count_ff  <= '0;
         first_ff      <= '0;
         second_ff     <= '0;
         num_idx_ff    <= '0;
         idx_ff        <= '0;
         rep_len_ff    <= '0;
         rep_esc_ff    <= 1'b0;
         total_ff      <= '0;
         sent_ff       <= '0;
         sub_ff        <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         cur_col_ff    <= cur_col_in;
         cur_row_ff    <= cur_row_in;
         saved_col_ff  <= saved_col_in;
         saved_row_ff  <= saved_row_in;
         palette_ff    <= palette_in;
         esc_active_ff <= esc_active_in;
         esc_count_ff  <= esc_count_in;
         first_ff      <= first_in;
         second_ff     <= second_in;
         num_idx_ff    <= num_idx_in;
         idx_ff        <= idx_in;
         rep_len_ff    <= rep_len_in;
         rep_esc_ff    <= rep_esc_in;
         total_ff      <= total_in;
         sent_ff       <= sent_in;
         sub_ff        <= sub_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      char_ff   <= char_in;
      wk_col_ff <= wk_col_in;
      wk_row_ff <= wk_row_in;
      cmd_ff    <= cmd_in;
      tcol_ff   <= tcol_in;
      trow_ff   <= trow_in;
      value_ff  <= value_in;
      ccol_ff   <= ccol_in;
      crow_ff   <= crow_in;
      last_ff   <= last_in;
   end

   always_ff @(posedge clock) begin
      if (buf_wr) esc_buf_ff[esc_count_ff[BW-1:0]] <= char_ff;
   end

endmodule
`default_nettype wire

[src/acv_put.sv]
// Shared character unit: applies one printable or control byte to the cursor.
`timescale 1ns / 1ps
`default_nettype none
module acv_put #(
   parameter int COLUMNS = acv_pkg::COLUMNS_DEF,
   parameter int ROWS    = acv_pkg::ROWS_DEF
) (
   input  wire logic [$clog2(COLUMNS)-1:0] col,
   input  wire logic [$clog2(ROWS)-1:0]    row,
   input  wire logic [3:0]                 palette,
   input  wire logic [7:0]                 char_code,
   output logic [$clog2(COLUMNS)-1:0]      new_col,
   output logic [$clog2(ROWS)-1:0]         new_row,
   output logic [$clog2(COLUMNS)-1:0]      wr_col,
   output logic [$clog2(ROWS)-1:0]         wr_row,
   output logic [15:0]                     wr_value,
   output acv_pkg::put_flags_type          flags
);
   localparam int CW = $clog2(COLUMNS);
   localparam int RW = $clog2(ROWS);

   logic [CW:0] col_tab;
   logic [CW:0] col_inc;
   logic [RW:0] row_inc;
   logic        row_wrap;
   logic [RW-1:0] row_next;

   assign col_tab  = {1'b0, col} + (CW+1)'(4) - (CW+1)'(col[1:0]);
   assign col_inc  = {1'b0, col} + (CW+1)'(1);
   assign row_inc  = {1'b0, row} + (RW+1)'(1);
   assign row_wrap = (row_inc >= (RW+1)'(ROWS));
   assign row_next = row_wrap ? RW'(ROWS - 1) : row_inc[RW-1:0];

   always_comb begin
      new_col      = col;
      new_row      = row;
      wr_col       = col;
      wr_row       = row;
      wr_value     = {palette, 4'b0000, char_code};
      flags.wr     = 1'b0;
      flags.scroll = 1'b0;
      case (char_code)
         acv_pkg::CH_NUL: begin
         end
         acv_pkg::CH_BS: begin
            if (col == '0) begin
               new_col = CW'(COLUMNS - 1);
               if (row != '0) new_row = row - RW'(1);
            end else begin
               new_col = col - CW'(1);
            end
            wr_col   = new_col;
            wr_row   = new_row;
            wr_value = {palette, 4'b0000, acv_pkg::CH_SPACE};
            flags.wr = 1'b1;
         end
         acv_pkg::CH_TAB: begin
            if (col_tab >= (CW+1)'(COLUMNS)) begin
               new_col      = '0;
               new_row      = row_next;
               flags.scroll = row_wrap;
            end else begin
               new_col = col_tab[CW-1:0];
            end
         end
         acv_pkg::CH_LF: begin
            new_col      = '0;
            new_row      = row_next;
            flags.scroll = row_wrap;
         end
         acv_pkg::CH_FF: begin
            new_col = '0;
         end
         default: begin
            flags.wr = 1'b1;
            if (col_inc >= (CW+1)'(COLUMNS)) begin
               new_col      = '0;
               new_row      = row_next;
               flags.scroll = row_wrap;
            end else begin
               new_col = col_inc[CW-1:0];
            end
         end
      endcase
   end

endmodule
`default_nettype wire

[src/acv_seq.sv]
// Escape sequence unit: parses one byte of an ESC [ sequence and applies final bytes.
`timescale 1ns / 1ps
`default_nettype none
module acv_seq #(
   parameter int COLUMNS = acv_pkg::COLUMNS_DEF,
   parameter int ROWS    = acv_pkg::ROWS_DEF
) (
   input  wire logic [7:0]                 char_code,
   input  wire logic                       first_byte,
   input  wire logic [$clog2(COLUMNS)-1:0] col,
   input  wire logic [$clog2(ROWS)-1:0]    row,
   input  wire logic [$clog2(COLUMNS)-1:0] saved_col,
   input  wire logic [$clog2(ROWS)-1:0]    saved_row,
   input  wire logic [3:0]                 palette,
   input  wire logic [7:0]                 first_num,
   input  wire logic [7:0]                 second_num,
   input  wire logic [1:0]                 num_idx,
   output logic [$clog2(COLUMNS)-1:0]      new_col,
   output logic [$clog2(ROWS)-1:0]         new_row,
   output logic [$clog2(COLUMNS)-1:0]      new_saved_col,
   output logic [$clog2(ROWS)-1:0]         new_saved_row,
   output logic [3:0]                      new_palette,
   output logic [7:0]                      new_first,
   output logic [7:0]                      new_second,
   output logic [1:0]                      new_num_idx,
   output acv_pkg::seq_ctl_type            ctl
);
   localparam int CW = $clog2(COLUMNS);
   localparam int RW = $clog2(ROWS);

   logic [8:0]        row_sum;
   logic [8:0]        col_sum;
   logic [11:0]       digit_acc;
   logic [7:0]        digit_sat;
   logic signed [9:0] pal_base;
   logic signed [9:0] pal_val;

   assign row_sum   = {1'b0, first_num} + 9'(row);
   assign col_sum   = {1'b0, first_num} + 9'(col);
   assign digit_acc = ((num_idx == 2'd0) ? 12'(first_num) : 12'(second_num)) * 12'd10
                      + 12'(char_code[3:0]);
   assign digit_sat = (digit_acc > 12'(acv_pkg::NUM_MAX)) ? acv_pkg::NUM_MAX
                                                          : digit_acc[7:0];
   assign pal_base  = signed'({2'b00, first_num} - acv_pkg::COLOR_BASE);

   always_comb begin
      if (pal_base == 10'sd9) pal_val = 10'sd15;
      else if (pal_base > 10'sd8) pal_val = pal_base - 10'sd2;
      else if (second_num != 8'd0) pal_val = pal_base + 10'sd8;
      else pal_val = pal_base;
   end

   always_comb begin
      new_col       = col;
      new_row       = row;
      new_saved_col = saved_col;
      new_saved_row = saved_row;
      new_palette   = palette;
      new_first     = first_num;
      new_second    = second_num;
      new_num_idx   = num_idx;
      ctl.done      = 1'b1;
      ctl.cmd       = acv_pkg::CMD_NONE;
      case (char_code)
         acv_pkg::CH_UP: begin
            new_row = (9'(first_num) >= 9'(row)) ? '0 : RW'(9'(row) - 9'(first_num));
         end
         acv_pkg::CH_DOWN: begin
            new_row = (row_sum >= 9'(ROWS)) ? RW'(ROWS - 1) : RW'(row_sum);
         end
         acv_pkg::CH_RIGHT: begin
            new_col = (col_sum >= 9'(COLUMNS)) ? CW'(COLUMNS - 1) : CW'(col_sum);
         end
         acv_pkg::CH_LEFT: begin
            new_col = (9'(first_num) >= 9'(col)) ? '0 : CW'(9'(col) - 9'(first_num));
         end
         acv_pkg::CH_POS, acv_pkg::CH_POSF: begin
            new_row = (9'(first_num) >= 9'(ROWS)) ? RW'(ROWS - 1) : RW'(first_num);
            new_col = (9'(second_num) >= 9'(COLUMNS)) ? CW'(COLUMNS - 1) : CW'(second_num);
         end
         acv_pkg::CH_CLRS: ctl.cmd = acv_pkg::CMD_CLR_SCRN;
         acv_pkg::CH_CLRL: ctl.cmd = acv_pkg::CMD_CLR_ROW;
         acv_pkg::CH_SAVE: begin
            new_saved_col = col;
            new_saved_row = row;
         end
         acv_pkg::CH_REST: begin
            new_col = saved_col;
            new_row = saved_row;
         end
         acv_pkg::CH_COLOR: new_palette = pal_val[3:0];
         default: begin
            ctl.done = 1'b0;
            if (first_byte) begin
            end else if (char_code >= acv_pkg::CH_ZERO && char_code <= acv_pkg::CH_NINE) begin
               if (num_idx == 2'd0) new_first = digit_sat;
               else if (num_idx == 2'd1) new_second = digit_sat;
            end else if (char_code == acv_pkg::CH_SEMI) begin
               if (num_idx != 2'd2) new_num_idx = num_idx + 2'd1;
            end else begin
               new_num_idx = 2'd2;
            end
         end
      endcase
   end

endmodule
`default_nettype wire
